// ===== rtl/fft_magnitude_spectrum_core_defines.svh =====
// assertion macros used by the rtl file fms_back.sv
`ifndef FFT_MAGNITUDE_SPECTRUM_CORE_DEFINES_SVH
`define FFT_MAGNITUDE_SPECTRUM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// immediate implication or plain condition checked at each clock edge
`define FMS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) cond) else $error(msg);
// condition that must hold in the cycle after a trigger
`define FMS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define FMS_ASSERT(lbl, cond, msg)
`define FMS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/fms_pkg.sv =====
`timescale 1ns / 1ps
package fms_pkg;

	localparam int MAX_POINTS   = 64;
	localparam int ADDR_BITS    = 6;
	localparam int LOG2_BITS    = 3;
	localparam int SAMPLE_BITS  = 16;
	localparam int TWIDDLE_BITS = 16;
	localparam int COMP_BITS    = 24;
	localparam int ENTRY_BITS   = 2 * COMP_BITS;
	localparam int PROD_BITS    = COMP_BITS + TWIDDLE_BITS;
	localparam int SUM_BITS     = PROD_BITS + 2;
	localparam int RAD_BITS     = 46;
	localparam int ROOT_BITS    = 23;
	localparam int SCALE_BITS   = 16;
	localparam int SCALED_BITS  = ROOT_BITS + SCALE_BITS;
	localparam int MAG_BITS     = 15;
	localparam int BFLY_BITS    = ADDR_BITS - 1;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_POINTS_LOG2 = 2'd0;
	localparam cfg_idx_t REG_MAG_SCALE   = 2'd1;
	localparam cfg_idx_t REG_MAX_MAG     = 2'd2;

	// one loaded sample on its way to the frame store
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [ADDR_BITS-1:0]          addr;
		logic                          last;
	} load_word_t;

	// settings seen by the transform engine
	typedef struct packed {
		logic [LOG2_BITS-1:0]  bits;
		logic [SCALE_BITS-1:0] scale;
		logic [MAG_BITS-1:0]   max_mag;
	} cfg_t;

	typedef struct packed {
		logic signed [TWIDDLE_BITS-1:0] wr;
		logic signed [TWIDDLE_BITS-1:0] wi;
	} twiddle_t;

	typedef enum logic [3:0] {
		S_LOAD, S_BF_RD, S_BF_MUL, S_BF_ADD, S_BF_WA, S_BF_WB,
		S_MAG_RD, S_MAG_SQ, S_MAG_SUM, S_SQRT, S_SCALE, S_OUT
	} back_state_t;

	// frame size clamped to the store depth
	function automatic logic [LOG2_BITS-1:0] eff_bits(input logic [LOG2_BITS-1:0] p);
		return (p > LOG2_BITS'(ADDR_BITS)) ? LOG2_BITS'(ADDR_BITS) : p;
	endfunction

	// index reversed over the low bits of the frame size
	function automatic logic [ADDR_BITS-1:0] bit_rev(input logic [ADDR_BITS-1:0] idx,
			input logic [LOG2_BITS-1:0] bits);
		logic [ADDR_BITS-1:0] r;
		for (int s = 0; s < ADDR_BITS; s++) begin
			r[s] = idx[ADDR_BITS-1-s];
		end
		return r >> (LOG2_BITS'(ADDR_BITS) - bits);
	endfunction

	// cosine of 2*pi*k/64 in q1.15 for k in 0..16
	function automatic logic signed [TWIDDLE_BITS-1:0] cos_q15(input logic [4:0] k);
		logic signed [TWIDDLE_BITS-1:0] c;
		case (k)
			5'd0:  c = 16'sd32767;
			5'd1:  c = 16'sd32610;
			5'd2:  c = 16'sd32138;
			5'd3:  c = 16'sd31357;
			5'd4:  c = 16'sd30274;
			5'd5:  c = 16'sd28899;
			5'd6:  c = 16'sd27246;
			5'd7:  c = 16'sd25330;
			5'd8:  c = 16'sd23170;
			5'd9:  c = 16'sd20788;
			5'd10: c = 16'sd18205;
			5'd11: c = 16'sd15447;
			5'd12: c = 16'sd12540;
			5'd13: c = 16'sd9512;
			5'd14: c = 16'sd6393;
			5'd15: c = 16'sd3212;
			default: c = 16'sd0;
		endcase
		return c;
	endfunction

	// w = exp(-j*2*pi*k/64) for k in 0..31
	function automatic twiddle_t twiddle(input logic [BFLY_BITS-1:0] k);
		twiddle_t t;
		logic [4:0] m;
		m = k - 5'd16;
		if (k < 5'd16) begin
			t.wr = cos_q15(k);
			t.wi = -cos_q15(5'd16 - k);
		end else begin
			t.wr = -cos_q15(5'd16 - m);
			t.wi = -cos_q15(m);
		end
		return t;
	endfunction

endpackage

// ===== rtl/fms_ram.sv =====
`timescale 1ns / 1ps
module fms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/fms_queue.sv =====
`timescale 1ns / 1ps
module fms_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  fms_pkg::load_word_t push_word,
	output logic                pop_valid,
	input  logic                pop_ready,
	output fms_pkg::load_word_t pop_word
);
	import fms_pkg::*;

	load_word_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_word   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// word storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

// ===== rtl/fms_front.sv =====
`timescale 1ns / 1ps
module fms_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [fms_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic [fms_pkg::LOG2_BITS-1:0]       bits,
	input  logic                                clear,
	output logic                                push_valid,
	input  logic                                push_ready,
	output fms_pkg::load_word_t                 push_word
);
	import fms_pkg::*;

	logic [ADDR_BITS-1:0] count_q;
	logic [ADDR_BITS-1:0] n_m1;
	logic                 last;

	// frame position decides the store address and the frame end
	assign n_m1     = ADDR_BITS'((7'd1 << bits) - 7'd1);
	assign last     = (count_q == n_m1);
	assign in_ready = push_ready;
	assign push_valid = in_valid;
	assign push_word.sample = sample_in;
	assign push_word.addr   = bit_rev(count_q, bits);
	assign push_word.last   = last;

	// samples loaded so far in this frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (in_valid && push_ready) begin
			count_q <= last ? '0 : count_q + 1'b1;
		end
	end

endmodule

// ===== rtl/fms_back.sv =====
`timescale 1ns / 1ps
`include "fft_magnitude_spectrum_core_defines.svh"
module fms_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fms_pkg::cfg_t                  cfg,
	input  logic                           q_valid,
	output logic                           q_ready,
	input  fms_pkg::load_word_t            q_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fms_pkg::ADDR_BITS-1:0]  bin_index,
	output logic [fms_pkg::MAG_BITS-1:0]   bin_magnitude,
	output logic                           last_bin
);
	import fms_pkg::*;

	back_state_t state_q, state_d;

	logic [LOG2_BITS-1:0] stage_q;
	logic [BFLY_BITS-1:0] bfly_q;
	logic [ADDR_BITS-1:0] bin_q;

	logic [BFLY_BITS-1:0] half_n_m1;
	logic [ADDR_BITS-1:0] n_m1;
	logic                 bfly_last;
	logic                 stage_last;
	logic [BFLY_BITS-1:0] jmask;
	logic [BFLY_BITS-1:0] j;
	logic [ADDR_BITS-1:0] hi;
	logic [ADDR_BITS-1:0] i_addr;
	logic [ADDR_BITS-1:0] p_addr;
	logic [BFLY_BITS-1:0] tw_k;
	logic                 out_free;

	logic                  ram_we;
	logic [ADDR_BITS-1:0]  ram_waddr;
	logic [ENTRY_BITS-1:0] ram_wdata;
	logic [ADDR_BITS-1:0]  ram_raddr_a;
	logic [ADDR_BITS-1:0]  ram_raddr_b;
	logic [ENTRY_BITS-1:0] ram_rdata_a;
	logic [ENTRY_BITS-1:0] ram_rdata_b;

	logic [ADDR_BITS-1:0]  i_q;
	logic [ADDR_BITS-1:0]  p_q;
	twiddle_t              tw_q;
	logic [ENTRY_BITS-1:0] a_q;
	logic signed [PROD_BITS-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
	logic [ENTRY_BITS-1:0] res_a_q;
	logic [ENTRY_BITS-1:0] res_b_q;
	logic signed [2*COMP_BITS-1:0] sq_re_q, sq_im_q;
	logic [RAD_BITS-1:0]   v_q;
	logic [RAD_BITS-1:0]   res_q;
	logic [RAD_BITS-1:0]   bit_q;
	logic [SCALED_BITS-1:0] scaled_q;

	logic signed [COMP_BITS-1:0] b_re, b_im, a_re, a_im, rd_re, rd_im;
	logic signed [SUM_BITS-1:0]  sum_r, sum_i;
	logic signed [COMP_BITS-1:0] tr, ti;
	logic [RAD_BITS-1:0]         trial;
	logic [SCALED_BITS-9:0]      sc;
	logic [MAG_BITS-1:0]         mag;

	logic                 out_valid_q;
	logic [ADDR_BITS-1:0] bin_index_q;
	logic [MAG_BITS-1:0]  bin_magnitude_q;
	logic                 last_bin_q;

	fms_ram #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr_a(ram_raddr_a),
		.raddr_b(ram_raddr_b),
		.rdata_a(ram_rdata_a),
		.rdata_b(ram_rdata_b)
	);

	// butterfly addressing within the current stage
	assign half_n_m1  = BFLY_BITS'(((7'd1 << cfg.bits) >> 1) - 7'd1);
	assign n_m1       = ADDR_BITS'((7'd1 << cfg.bits) - 7'd1);
	assign bfly_last  = (bfly_q == half_n_m1);
	assign stage_last = (stage_q == cfg.bits - 3'd1);
	assign jmask      = BFLY_BITS'((6'd1 << stage_q) - 6'd1);
	assign j          = bfly_q & jmask;
	assign hi         = {1'b0, bfly_q} >> stage_q;
	assign i_addr     = (hi << (stage_q + 3'd1)) | {1'b0, j};
	assign p_addr     = i_addr | (ADDR_BITS'(1) << stage_q);
	assign tw_k       = j << (3'd5 - stage_q);
	assign out_free   = !out_valid_q || out_ready;

	// butterfly and magnitude arithmetic
	assign b_re  = ram_rdata_b[ENTRY_BITS-1:COMP_BITS];
	assign b_im  = ram_rdata_b[COMP_BITS-1:0];
	assign rd_re = ram_rdata_a[ENTRY_BITS-1:COMP_BITS];
	assign rd_im = ram_rdata_a[COMP_BITS-1:0];
	assign a_re  = a_q[ENTRY_BITS-1:COMP_BITS];
	assign a_im  = a_q[COMP_BITS-1:0];
	assign sum_r = SUM_BITS'(p_rr_q) - SUM_BITS'(p_ii_q)
		+ SUM_BITS'(1 << (TWIDDLE_BITS - 2));
	assign sum_i = SUM_BITS'(p_ri_q) + SUM_BITS'(p_ir_q)
		+ SUM_BITS'(1 << (TWIDDLE_BITS - 2));
	assign tr    = sum_r[TWIDDLE_BITS-1+COMP_BITS-1:TWIDDLE_BITS-1];
	assign ti    = sum_i[TWIDDLE_BITS-1+COMP_BITS-1:TWIDDLE_BITS-1];
	assign trial = res_q + bit_q;
	assign sc    = scaled_q[SCALED_BITS-1:8];
	assign mag   = (sc > (SCALED_BITS-8)'(cfg.max_mag)) ? cfg.max_mag : sc[MAG_BITS-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_LOAD: begin
				if (q_valid && q_word.last) begin
					state_d = (cfg.bits == '0) ? S_MAG_RD : S_BF_RD;
				end
			end
			S_BF_RD:  state_d = S_BF_MUL;
			S_BF_MUL: state_d = S_BF_ADD;
			S_BF_ADD: state_d = S_BF_WA;
			S_BF_WA:  state_d = S_BF_WB;
			S_BF_WB:  state_d = (bfly_last && stage_last) ? S_MAG_RD : S_BF_RD;
			S_MAG_RD:  state_d = S_MAG_SQ;
			S_MAG_SQ:  state_d = S_MAG_SUM;
			S_MAG_SUM: state_d = S_SQRT;
			S_SQRT:    state_d = bit_q[0] ? S_SCALE : S_SQRT;
			S_SCALE:   state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = (bin_q == n_m1) ? S_LOAD : S_MAG_RD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	// memory port and queue control
	always_comb begin
		q_ready     = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = i_q;
		ram_wdata   = res_a_q;
		ram_raddr_a = i_addr;
		ram_raddr_b = p_addr;
		case (state_q)
			S_LOAD: begin
				q_ready   = 1'b1;
				ram_we    = q_valid;
				ram_waddr = q_word.addr;
				ram_wdata = {{(COMP_BITS-SAMPLE_BITS){q_word.sample[SAMPLE_BITS-1]}},
					q_word.sample, {COMP_BITS{1'b0}}};
			end
			S_BF_WA: begin
				ram_we = 1'b1;
			end
			S_BF_WB: begin
				ram_we    = 1'b1;
				ram_waddr = p_q;
				ram_wdata = res_b_q;
			end
			S_MAG_RD: begin
				ram_raddr_a = bin_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			stage_q <= '0;
			bfly_q  <= '0;
			bin_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_LOAD && q_valid && q_word.last) begin
				stage_q <= '0;
				bfly_q  <= '0;
				bin_q   <= '0;
			end
			if (state_q == S_BF_WB) begin
				if (bfly_last) begin
					bfly_q  <= '0;
					stage_q <= stage_q + 3'd1;
				end else begin
					bfly_q <= bfly_q + 1'b1;
				end
			end
			if (state_q == S_OUT && out_free) begin
				bin_q <= bin_q + 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_BF_RD: begin
				i_q  <= i_addr;
				p_q  <= p_addr;
				tw_q <= twiddle(tw_k);
			end
			S_BF_MUL: begin
				a_q    <= ram_rdata_a;
				p_rr_q <= tw_q.wr * b_re;
				p_ii_q <= tw_q.wi * b_im;
				p_ri_q <= tw_q.wr * b_im;
				p_ir_q <= tw_q.wi * b_re;
			end
			S_BF_ADD: begin
				res_a_q <= {a_re + tr, a_im + ti};
				res_b_q <= {a_re - tr, a_im - ti};
			end
			S_MAG_SQ: begin
				sq_re_q <= rd_re * rd_re;
				sq_im_q <= rd_im * rd_im;
			end
			S_MAG_SUM: begin
				v_q   <= sq_re_q[RAD_BITS-1:0] + sq_im_q[RAD_BITS-1:0];
				res_q <= '0;
				bit_q <= RAD_BITS'(1) << (2 * (ROOT_BITS - 1));
			end
			S_SQRT: begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_SCALE: begin
				scaled_q <= res_q[ROOT_BITS-1:0] * cfg.scale;
			end
			default: begin
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			bin_index_q     <= bin_q;
			bin_magnitude_q <= mag;
			last_bin_q      <= (bin_q == n_m1);
		end
	end

	assign out_valid     = out_valid_q;
	assign bin_index     = bin_index_q;
	assign bin_magnitude = bin_magnitude_q;
	assign last_bin      = last_bin_q;

	`FMS_ASSERT(a_sqrt_onehot, (state_q == S_SQRT) |-> $onehot(bit_q), "sqrt step bit lost")
	`FMS_ASSERT_NEXT(a_wb_exit, state_q == S_BF_WB, (state_q == S_BF_RD) || (state_q == S_MAG_RD), "bad exit from butterfly write")
	`FMS_ASSERT(a_root_width, (state_q == S_SCALE) |-> (res_q[RAD_BITS-1:ROOT_BITS] == '0), "root wider than expected")

endmodule

// ===== rtl/fft_magnitude_spectrum_core.sv =====
`timescale 1ns / 1ps
// channel  direction  handshake                payload
// in       input      in_valid / in_ready      sample_in
// out      output     out_valid / out_ready    bin_index, bin_magnitude, last_bin
// cfg      input      cfg_valid / cfg_ready    cfg_index, cfg_data
//
// samples are taken one a cycle while the engine is loading a frame
// a frame of N points then runs (N/2)*log2(N) butterflies on one shared butterfly
// unit, each as read, multiply, add and write steps, then per bin a read, square,
// sum, 23-step square root, scale and output; input stalls once the queue is full
// reset clears control state only; the frame store is not cleared
module fft_magnitude_spectrum_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [fms_pkg::SAMPLE_BITS-1:0] sample_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [fms_pkg::ADDR_BITS-1:0]         bin_index,
	output logic [fms_pkg::MAG_BITS-1:0]          bin_magnitude,
	output logic                                  last_bin,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fms_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [fms_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
	import fms_pkg::*;

	logic [LOG2_BITS-1:0]  points_log2_q;
	logic [SCALE_BITS-1:0] magnitude_scale_q;
	logic [MAG_BITS-1:0]   max_magnitude_q;
	logic                  clear;
	cfg_t                  cfg;
	logic                  push_valid, push_ready;
	load_word_t            push_word;
	logic                  q_valid, q_ready;
	load_word_t            q_word;

	assign cfg_ready = 1'b1;
	assign clear     = cfg_valid && (cfg_index == REG_POINTS_LOG2);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_log2_q     <= LOG2_BITS'(6);
			magnitude_scale_q <= SCALE_BITS'(256);
			max_magnitude_q   <= MAG_BITS'(32767);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_POINTS_LOG2: points_log2_q     <= cfg_data[LOG2_BITS-1:0];
				REG_MAG_SCALE:   magnitude_scale_q <= cfg_data[SCALE_BITS-1:0];
				REG_MAX_MAG:     max_magnitude_q   <= cfg_data[MAG_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.bits    = eff_bits(points_log2_q);
	assign cfg.scale   = magnitude_scale_q;
	assign cfg.max_mag = max_magnitude_q;

	fms_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.bits(cfg.bits),
		.clear(clear),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_word(push_word)
	);

	fms_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_word(push_word),
		.pop_valid(q_valid),
		.pop_ready(q_ready),
		.pop_word(q_word)
	);

	fms_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_valid(q_valid),
		.q_ready(q_ready),
		.q_word(q_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bin_index(bin_index),
		.bin_magnitude(bin_magnitude),
		.last_bin(last_bin)
	);

endmodule

// ===== verif/fms_checker.sv =====
`timescale 1ns / 1ps
module fms_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic signed [fms_pkg::SAMPLE_BITS-1:0] sample_in,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic [fms_pkg::ADDR_BITS-1:0]          bin_index,
	input  logic [fms_pkg::MAG_BITS-1:0]           bin_magnitude,
	input  logic                                   last_bin,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  logic [fms_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [fms_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	output int                                     errors,
	output int                                     bins_pending,
	output int                                     bins_checked
);
	import fms_pkg::*;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	typedef struct {
		logic [ADDR_BITS-1:0] idx;
		logic [MAG_BITS-1:0]  mag;
		logic                 last;
	} bin_word_t;

	bin_word_t spectrum_q[$];

	// predictor copy of the block state
	longint          frame_re [MAX_POINTS];
	longint          frame_im [MAX_POINTS];
	int              fill_count;
	logic [2:0]      size_log2;
	logic [15:0]     gain_q8;
	logic [14:0]     ceiling;

	// taylor series of cos or sin in q30 for 0 <= x <= pi/2
	function automatic longint unsigned taylor_q30(input longint unsigned x, input bit odd);
		longint unsigned term;
		longint sum;
		term = odd ? x : ONE_Q30;
		sum = longint'(term);
		for (int n = 1; n <= 14; n++) begin
			term = (((term * x) >> 30) * x) >> 30;
			term = term / (odd ? longint'((2*n) * (2*n+1)) : longint'((2*n-1) * (2*n)));
			sum = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
		return longint'(sum);
	endfunction

	// q30 value rounded to q1.15 with sign
	function automatic longint q15_of(input longint unsigned v, input bit neg);
		longint unsigned m;
		m = (v + 64'd16384) >> 15;
		if (m > 64'd32767) m = 64'd32767;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	task automatic rotation(input int k, input int len, output longint wr, output longint wi);
		longint unsigned x;
		if (4*k < len) begin
			x = (2 * PI_Q30 * k) / len;
			wr = q15_of(taylor_q30(x, 0), 0);
			wi = q15_of(taylor_q30(x, 1), 1);
		end else begin
			x = (2 * PI_Q30 * (k - len/4)) / len;
			wr = q15_of(taylor_q30(x, 1), 1);
			wi = q15_of(taylor_q30(x, 0), 1);
		end
	endtask

	function automatic longint unsigned root64(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic longint unsigned abs_clamped(input longint x);
		longint unsigned m;
		m = (x < 0) ? longint'(-x) : longint'(x);
		return (m > (64'd1 << 31)) ? (64'd1 << 31) : m;
	endfunction

	// in-place dit transform then queue every bin
	task automatic run_spectrum(input int n, input int nbits);
		int r;
		longint t, wr, wi, tr, ti, ar, ai, br, bi;
		longint unsigned mr, mi, mag, sc;
		bin_word_t w;
		for (int i = 0; i < n; i++) begin
			r = 0;
			for (int s = 0; s < nbits; s++)
				if (i[s]) r = r | (1 << (nbits - 1 - s));
			if (r > i) begin
				t = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = t;
				t = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = t;
			end
		end
		for (int len = 2; len <= n; len = len * 2) begin
			for (int j = 0; j < len/2; j++) begin
				rotation(j, len, wr, wi);
				for (int i = j; i < n; i += len) begin
					ar = frame_re[i]; ai = frame_im[i];
					br = frame_re[i+len/2]; bi = frame_im[i+len/2];
					tr = (wr * br - wi * bi + 64'sd16384) >>> 15;
					ti = (wr * bi + wi * br + 64'sd16384) >>> 15;
					frame_re[i] = ar + tr;
					frame_im[i] = ai + ti;
					frame_re[i+len/2] = ar - tr;
					frame_im[i+len/2] = ai - ti;
				end
			end
		end
		for (int i = 0; i < n; i++) begin
			mr = abs_clamped(frame_re[i]);
			mi = abs_clamped(frame_im[i]);
			mag = root64(mr * mr + mi * mi);
			sc = (mag * gain_q8) >> 8;
			if (sc > ceiling) sc = ceiling;
			w.idx = i[ADDR_BITS-1:0];
			w.mag = sc[MAG_BITS-1:0];
			w.last = (i == n - 1);
			spectrum_q.push_back(w);
		end
	endtask

	task automatic take_sample(input logic signed [SAMPLE_BITS-1:0] smp);
		int nbits, n;
		nbits = (size_log2 > 3'd6) ? 6 : size_log2;
		n = 1 << nbits;
		if (fill_count >= n) fill_count = 0;
		frame_re[fill_count] = smp;
		frame_im[fill_count] = 0;
		fill_count++;
		if (fill_count == n) begin
			fill_count = 0;
			run_spectrum(n, nbits);
		end
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		bin_word_t w;
		if (!arst_n) begin
			spectrum_q.delete();
			fill_count = 0;
			size_log2 = 3'd6;
			gain_q8 = 16'd256;
			ceiling = 15'd32767;
			errors = 0;
			bins_checked = 0;
			bins_pending = 0;
		end else begin
			// compare result word with oldest expectation
			if (out_valid && out_ready) begin
				bins_checked++;
				if (spectrum_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected bin word: index %0d magnitude %0d last %0b",
							bin_index, bin_magnitude, last_bin);
				end else begin
					w = spectrum_q.pop_front();
					if (w.idx !== bin_index || w.mag !== bin_magnitude || w.last !== last_bin) begin
						errors++;
						if (errors <= 10)
							$display("bin mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
								w.idx, w.mag, w.last, bin_index, bin_magnitude, last_bin);
					end
				end
			end
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_POINTS_LOG2: begin
						size_log2 = cfg_data[2:0];
						fill_count = 0;
					end
					REG_MAG_SCALE: gain_q8 = cfg_data;
					REG_MAX_MAG: ceiling = cfg_data[14:0];
					default: ;
				endcase
			end
			// sample word
			if (in_valid && in_ready)
				take_sample(sample_in);
			bins_pending = spectrum_q.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import fms_pkg::*;

	localparam cfg_idx_t REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic out_valid;
	logic out_ready;
	logic [ADDR_BITS-1:0] bin_index;
	logic [MAG_BITS-1:0] bin_magnitude;
	logic last_bin;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	int errors;
	int bins_pending;
	int bins_checked;
	int samples_sent;
	int frames_sent;
	int cycles;
	bit calm;
	bit stall_done;
	bit hold_req;

	fft_magnitude_spectrum_core dut (.*);

	fms_checker checker_i (.*);

	// clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** fft_magnitude_spectrum_core: FAILED **");
			$finish;
		end
	end

	// receiver side with one long hold-off
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!stall_done && hold_req) begin
				stall_done = 1'b1;
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 11);
		end
	end

	// offer one sample word, may leave valid high for the next one
	task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
		in_valid <= 1'b1;
		sample_in <= v;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
		if (!calm && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// lower valid and let the block settle before a register write
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bins_pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame(input int nbits, input int style);
		logic signed [SAMPLE_BITS-1:0] v;
		for (int i = 0; i < (1 << nbits); i++) begin
			case (style)
				0: v = 16'($urandom);
				1: v = $signed(16'($urandom_range(0, 63))) - 16'sd32;
				2: v = ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
				default: v = (i % 2) ? 16'sh8000 : 16'sh7fff;
			endcase
			send_sample(v);
		end
		frames_sent++;
	endtask

	int nbits;
	int pl;

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		calm = 1'b0;
		stall_done = 1'b0;
		hold_req = 1'b0;
		samples_sent = 0;
		frames_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-point frames, widest gain
		write_reg(REG_POINTS_LOG2, 16'd0);
		write_reg(REG_MAG_SCALE, 16'hffff);
		write_reg(REG_UNUSED, 16'h1234);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sd0);
		send_sample(16'sd1);
		frames_sent += 4;
		drain();
		// two and four points at the sample extremes
		write_reg(REG_POINTS_LOG2, 16'd1);
		write_reg(REG_MAG_SCALE, 16'd256);
		send_frame(1, 3);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		frames_sent++;
		drain();
		write_reg(REG_POINTS_LOG2, 16'd2);
		send_frame(2, 2);
		drain();
		// size change drops a partial frame
		write_reg(REG_POINTS_LOG2, 16'd3);
		send_sample(16'sh7fff);
		send_sample(16'sh1234);
		send_sample(-16'sd5);
		drain();
		write_reg(REG_POINTS_LOG2, 16'd2);
		write_reg(REG_MAX_MAG, 16'd0);
		send_frame(2, 0);
		drain();
		write_reg(REG_MAX_MAG, 16'h7fff);
		write_reg(REG_MAG_SCALE, 16'd0);
		send_frame(2, 0);
		drain();
		// receiver holds off while short frames keep coming, block fills up
		write_reg(REG_MAG_SCALE, 16'd256);
		hold_req = 1'b1;
		repeat (3) send_frame(2, 0);
		drain();

		// random frames, mostly small sizes
		while (samples_sent < 260) begin
			calm = (samples_sent >= 60 && samples_sent < 110);
			case ($urandom_range(0, 9))
				0: pl = 7;
				1: pl = 6;
				2: pl = 5;
				default: pl = $urandom_range(0, 4);
			endcase
			write_reg(REG_POINTS_LOG2, 16'(pl));
			case ($urandom_range(0, 4))
				0: write_reg(REG_MAG_SCALE, 16'd0);
				1: write_reg(REG_MAG_SCALE, 16'hffff);
				2: write_reg(REG_MAG_SCALE, 16'd256);
				default: write_reg(REG_MAG_SCALE, 16'($urandom));
			endcase
			case ($urandom_range(0, 3))
				0: write_reg(REG_MAX_MAG, 16'd0);
				1: write_reg(REG_MAX_MAG, 16'h7fff);
				default: write_reg(REG_MAX_MAG, 16'($urandom_range(0, 32767)));
			endcase
			nbits = (pl > 6) ? 6 : pl;
			repeat ((nbits > 4) ? 1 : $urandom_range(1, 4))
				send_frame(nbits, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3));
			// now and then leave a broken frame behind
			if (nbits > 1 && $urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, (1 << nbits) - 1)) send_sample(16'($urandom));
			end
			drain();
		end

		in_valid <= 1'b0;
		while (bins_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d samples in %0d frames, %0d bins checked", samples_sent,
			frames_sent, bins_checked);
		$display("sizes 1..64 points plus oversize, gain and ceiling extremes, partial frames");
		if (errors == 0)
			$display("** fft_magnitude_spectrum_core: PASSED **");
		else
			$display("** fft_magnitude_spectrum_core: FAILED **");
		$finish;
	end

endmodule
